@@ hw/rtl/b52tp_pkg.sv @@
// Shared types, constants and character helpers for the base-52 text pair codec.
package b52tp_pkg;

  // Direction register codes
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // End-result status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_ERR  = 2'd1;
  localparam logic [1:0] STATUS_NULL = 2'd2;

  // Characters with a meaning of their own
  localparam logic [7:0] CHAR_EMPTY = 8'h7A;  // 'z'
  localparam logic [7:0] CHAR_NULL  = 8'h6E;  // 'n'

  // Triple arithmetic
  localparam int unsigned  RADIX       = 52;
  localparam logic [16:0]  TRIPLE_BASE = 17'd2704;  // RADIX * RADIX
  // Exact reciprocals for values below 2^17: floor(v/52) and floor(v/2704)
  localparam logic [34:0]  RECIP_RADIX = 35'd161320;
  localparam int unsigned  SHIFT_RADIX = 23;
  localparam logic [33:0]  RECIP_BASE  = 34'd99274;
  localparam int unsigned  SHIFT_BASE  = 28;

  localparam int unsigned  MAX_RESULTS = 4;

  // Digit 0 sits in the top byte
  localparam logic [8*RADIX-1:0] ALPHABET =
    "0123456789!%-@ABCDEFGHJKLMNPQRSTVWXYZabcdeghikmpqsty";

  typedef struct packed {
    logic [7:0] symbol;
    logic       last_of_string;
    logic       empty_string;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_end;
    logic [1:0] status;
    logic       last;
  } out_t;

  typedef out_t [MAX_RESULTS-1:0] slots_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_EMPTY,
    KIND_TRIPLE,
    KIND_PAIR
  } kind_e;

  // Command handed from the front stage to the result expander
  typedef struct packed {
    kind_e       kind;
    logic        is_end;
    logic [1:0]  status;
    logic [16:0] val;       // encode: 2704 + first*256 + second
    logic [10:0] quot52;    // val / 52
    logic [4:0]  quot2704;  // val / 2704
    logic [7:0]  hi_byte;   // decode
    logic [7:0]  lo_byte;
  } cmd_t;

  typedef struct packed {
    logic adv;   // front consumes its input item
    logic take;  // command register is moved into the result buffer
  } front_ctl_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] value;
  } digit_t;

  // Character for a digit 0..51
  function automatic logic [7:0] alpha_char(input logic [5:0] d);
    logic [5:0] pos;
    pos = 6'(RADIX - 1) - d;
    return ALPHABET[{pos, 3'b000} +: 8];
  endfunction

  // Digit of a character, hit low when it is not in the alphabet
  function automatic digit_t digit_of(input logic [7:0] ch);
    digit_t r;
    r = '0;
    for (int i = 0; i < RADIX; i++) begin
      if (ALPHABET[8*(RADIX-1-i) +: 8] == ch) begin
        r.hit   = 1'b1;
        r.value = 6'(i);
      end
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/base52_text_pair_codec_core.sv @@
// Top level of the base-52 text pair codec: input register, front stage, result buffer.
//
//  channel | direction | handshake              | beat
//  --------+-----------+------------------------+------------------------------
//  in      | into core | in_valid_i / in_stall_o | in_t: symbol, last, empty flag
//  out     | from core | out_valid_o / out_stall_i | out_t: byte, end, status, last
//  cfg     | into core | cfg_we_i               | direction bit, no read-back
//
// An item passes through the input register and then the command register
// before its result beats are loaded into the result buffer.
// The result buffer drains one beat per cycle while out_stall_i is low.
// A new batch loads in the cycle the previous last beat leaves.
// Reset clears the string state; a direction write also drops the open string.
// out_stall_i backs up through the buffer, command and input registers.
module base52_text_pair_codec_core import b52tp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic       s1_valid_q, s1_valid_d;
  in_t        s1_data_q;
  logic       in_accept;
  logic       s1_adv;

  cmd_t       cmd;
  logic       cmd_valid;
  front_ctl_t ctl;

  slots_t     slots;
  logic [2:0] slot_count;
  slots_t     entries_q, entries_d;
  logic [2:0] count_q, count_d;
  logic       out_fire;
  logic       batch_free;
  logic       load;

  // Handshake and stage advance
  assign out_fire   = out_valid_o && !out_stall_i;
  assign batch_free = (count_q == 3'd0) || (count_q == 3'd1 && out_fire);
  assign load       = cmd_valid && batch_free;
  assign s1_adv     = s1_valid_q && (!cmd_valid || load);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign ctl = '{adv: s1_adv, take: load};

  // Input register
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_data_q <= in_data_i;
    end
  end

  b52tp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (s1_data_q),
    .ctl_i       (ctl),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid)
  );

  b52tp_expand u_expand (
    .cmd_i   (cmd),
    .slots_o (slots),
    .count_o (slot_count)
  );

  // Result buffer: beat 0 is on the port, shifts down on each beat taken
  always_comb begin
    entries_d = entries_q;
    count_d   = count_q;
    if (load) begin
      entries_d = slots;
      count_d   = slot_count;
    end else if (out_fire) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        entries_d[i] = entries_q[i+1];
      end
      entries_d[MAX_RESULTS-1] = '0;
      count_d = count_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entries_q <= entries_d;
  end

  // Output beat
  assign out_valid_o = (count_q != 3'd0);
  always_comb begin
    out_data_o      = entries_q[0];
    out_data_o.last = (count_q == 3'd1);
  end

  // Checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 3'(MAX_RESULTS))
    else $error("result buffer count out of range");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_end |-> out_data_o.last)
    else $error("end beat is not the last beat of its item");

  a_data_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.is_end |-> out_data_o.status == STATUS_OK)
    else $error("data beat carries a status");

  a_cmd_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid && !load && !cfg_we_i |=> cmd_valid && $stable(cmd))
    else $error("command lost before it reached the result buffer");

endmodule

@@ hw/rtl/b52tp_front.sv @@
// Front stage: string state, per-item decisions and the registered command.
module b52tp_front import b52tp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  in_t        item_i,
  input  front_ctl_t ctl_i,
  output cmd_t       cmd_o,
  output logic       cmd_valid_o
);

  logic        direction_q;
  logic [7:0]  held_byte_q, held_byte_d;
  logic        have_held_q, have_held_d;
  logic [17:0] digit_accum_q, digit_accum_d;
  logic [1:0]  digit_count_q, digit_count_d;
  logic        at_start_q, at_start_d;
  logic        halted_q, halted_d;
  logic        failed_q, failed_d;

  cmd_t        cmd_q, cmd_d;
  logic        cmd_valid_q, cmd_valid_d;

  logic        ending;
  logic        null_hit;
  logic [7:0]  first_b, second_b;
  digit_t      dig;
  logic [17:0] diff;
  logic [34:0] prod52;
  logic [33:0] prod2704;

  assign ending = item_i.last_of_string | item_i.empty_string;
  assign dig    = digit_of(item_i.symbol);

  // Per-item decision and next string state
  always_comb begin
    held_byte_d   = held_byte_q;
    have_held_d   = have_held_q;
    digit_accum_d = digit_accum_q;
    digit_count_d = digit_count_q;
    at_start_d    = 1'b0;
    halted_d      = halted_q;
    failed_d      = failed_q;
    null_hit      = 1'b0;
    first_b       = item_i.symbol;
    second_b      = '0;
    diff          = '0;
    cmd_d         = '0;
    cmd_d.kind    = KIND_NONE;

    if (direction_q == DIR_ENCODE) begin
      if (item_i.empty_string) begin
        if (at_start_q) begin
          cmd_d.kind = KIND_EMPTY;
        end else if (have_held_q) begin
          cmd_d.kind = KIND_TRIPLE;
          first_b    = held_byte_q;
        end
      end else if (have_held_q) begin
        cmd_d.kind  = KIND_TRIPLE;
        first_b     = held_byte_q;
        second_b    = item_i.symbol;
        have_held_d = 1'b0;
      end else if (item_i.last_of_string) begin
        cmd_d.kind = KIND_TRIPLE;
      end else begin
        held_byte_d = item_i.symbol;
        have_held_d = 1'b1;
      end
    end else begin
      if (item_i.empty_string) begin
        if (at_start_q) begin
          failed_d = 1'b1;
        end
      end else if (at_start_q && item_i.last_of_string
                   && item_i.symbol == CHAR_EMPTY) begin
        null_hit = 1'b0;
      end else if (at_start_q && item_i.last_of_string
                   && item_i.symbol == CHAR_NULL) begin
        null_hit = 1'b1;
      end else if (!halted_q) begin
        if (!dig.hit) begin
          failed_d = 1'b1;
          halted_d = 1'b1;
        end else begin
          digit_accum_d = 18'(digit_accum_q * 18'(RADIX) + 18'(dig.value));
          digit_count_d = digit_count_q + 2'd1;
          if (digit_count_q == 2'd2) begin
            // triple complete
            if (digit_accum_d < 18'(TRIPLE_BASE)) begin
              halted_d = 1'b1;
            end else begin
              diff          = digit_accum_d - 18'(TRIPLE_BASE);
              cmd_d.kind    = KIND_PAIR;
              cmd_d.hi_byte = diff[15:8];
              cmd_d.lo_byte = diff[7:0];
            end
            digit_accum_d = '0;
            digit_count_d = '0;
          end
        end
      end
      if (ending && !halted_d && digit_count_d != 2'd0) begin
        failed_d = 1'b1;
      end
    end

    // End of string: close with status and drop all string state
    if (ending) begin
      cmd_d.is_end  = 1'b1;
      if (direction_q == DIR_DECODE) begin
        cmd_d.status = null_hit ? STATUS_NULL : (failed_d ? STATUS_ERR : STATUS_OK);
      end
      held_byte_d   = '0;
      have_held_d   = 1'b0;
      digit_accum_d = '0;
      digit_count_d = '0;
      at_start_d    = 1'b1;
      halted_d      = 1'b0;
      failed_d      = 1'b0;
    end

    // Pair value and its base-52 quotients
    cmd_d.val      = TRIPLE_BASE + {1'b0, first_b, second_b};
    prod52         = 35'(cmd_d.val) * RECIP_RADIX;
    prod2704       = 34'(cmd_d.val) * RECIP_BASE;
    cmd_d.quot52   = prod52[SHIFT_RADIX +: 11];
    cmd_d.quot2704 = prod2704[SHIFT_BASE +: 5];
  end

  // Command register valid
  always_comb begin
    cmd_valid_d = cmd_valid_q;
    if (ctl_i.adv) begin
      cmd_valid_d = cmd_d.is_end || (cmd_d.kind != KIND_NONE);
    end else if (ctl_i.take) begin
      cmd_valid_d = 1'b0;
    end
  end

  // String state and direction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q   <= DIR_ENCODE;
      held_byte_q   <= '0;
      have_held_q   <= 1'b0;
      digit_accum_q <= '0;
      digit_count_q <= '0;
      at_start_q    <= 1'b1;
      halted_q      <= 1'b0;
      failed_q      <= 1'b0;
      cmd_valid_q   <= 1'b0;
    end else if (cfg_we_i) begin
      direction_q   <= cfg_wdata_i;
      held_byte_q   <= '0;
      have_held_q   <= 1'b0;
      digit_accum_q <= '0;
      digit_count_q <= '0;
      at_start_q    <= 1'b1;
      halted_q      <= 1'b0;
      failed_q      <= 1'b0;
      cmd_valid_q   <= 1'b0;
    end else begin
      cmd_valid_q <= cmd_valid_d;
      if (ctl_i.adv) begin
        held_byte_q   <= held_byte_d;
        have_held_q   <= have_held_d;
        digit_accum_q <= digit_accum_d;
        digit_count_q <= digit_count_d;
        at_start_q    <= at_start_d;
        halted_q      <= halted_d;
        failed_q      <= failed_d;
      end
    end
  end

  // Command payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_o       = cmd_q;
  assign cmd_valid_o = cmd_valid_q;

endmodule

@@ hw/rtl/b52tp_expand.sv @@
// Result expander: turns one command into the list of result beats.
module b52tp_expand import b52tp_pkg::*; (
  input  cmd_t       cmd_i,
  output slots_t     slots_o,
  output logic [2:0] count_o
);

  logic [7:0]  data_b [MAX_RESULTS];
  logic [2:0]  ndata;
  logic [10:0] mid_digit;
  logic [16:0] low_digit;

  // Middle and low digits from the stored quotients
  assign mid_digit = cmd_i.quot52 - 11'(cmd_i.quot2704) * 11'(RADIX);
  assign low_digit = cmd_i.val - 17'(cmd_i.quot52) * 17'(RADIX);

  // Data bytes of this command
  always_comb begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      data_b[i] = '0;
    end
    ndata = 3'd0;
    case (cmd_i.kind)
      KIND_EMPTY: begin
        data_b[0] = CHAR_EMPTY;
        ndata     = 3'd1;
      end
      KIND_TRIPLE: begin
        data_b[0] = alpha_char(6'(cmd_i.quot2704));
        data_b[1] = alpha_char(mid_digit[5:0]);
        data_b[2] = alpha_char(low_digit[5:0]);
        ndata     = 3'd3;
      end
      KIND_PAIR: begin
        data_b[0] = cmd_i.hi_byte;
        data_b[1] = cmd_i.lo_byte;
        ndata     = 3'd2;
      end
      default: begin
        ndata = 3'd0;
      end
    endcase
  end

  // Data beats first, then the end beat
  always_comb begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (3'(i) < ndata) begin
        slots_o[i] = '{out_byte: data_b[i], is_end: 1'b0, status: STATUS_OK, last: 1'b0};
      end else begin
        slots_o[i] = '{out_byte: 8'd0, is_end: 1'b1, status: cmd_i.status, last: 1'b0};
      end
    end
  end

  assign count_o = ndata + 3'(cmd_i.is_end);

endmodule
